FILE: rtl/thick_line_rasterizer_assert.svh
// Assertion macros shared by the thick line rasterizer RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef THICK_LINE_RASTERIZER_ASSERT_SVH
`define THICK_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TLR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TLR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tlr_pkg.sv
// Package for the thick line rasterizer: widths, microcode word layout,
// the microcode program and the structs passed between modules. No dependencies.
package tlr_pkg;

    localparam int GRID_DIM    = 128;
    localparam int COORD_W     = $clog2(GRID_DIM);
    localparam int SCOORD_W    = COORD_W + 2;
    localparam int RUNERR_W    = COORD_W + 3;
    localparam int SIDEERR_W   = COORD_W + 5;
    localparam int WIDTH_W     = 4;
    localparam int HW_W        = 4;
    localparam int HW2_W       = 7;
    localparam int ED2_W       = 2 * COORD_W + 1;
    localparam int REACH_W     = ED2_W + HW2_W;
    localparam int MUL_A_W     = ED2_W;
    localparam int MUL_B_W     = SIDEERR_W - 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int UPC_W       = 5;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Microcode addresses
    localparam logic [UPC_W-1:0] UA_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] UA_LD_DELTA = 5'd1;
    localparam logic [UPC_W-1:0] UA_LD_SQX   = 5'd2;
    localparam logic [UPC_W-1:0] UA_LD_SQY   = 5'd3;
    localparam logic [UPC_W-1:0] UA_LD_SUM   = 5'd4;
    localparam logic [UPC_W-1:0] UA_LD_HW2   = 5'd5;
    localparam logic [UPC_W-1:0] UA_LD_SCALE = 5'd6;
    localparam logic [UPC_W-1:0] UA_LD_LIMIT = 5'd7;
    localparam logic [UPC_W-1:0] UA_TOP      = 5'd8;
    localparam logic [UPC_W-1:0] UA_AFTER    = 5'd9;
    localparam logic [UPC_W-1:0] UA_RUNA_SQ  = 5'd10;
    localparam logic [UPC_W-1:0] UA_RUNA     = 5'd11;
    localparam logic [UPC_W-1:0] UA_RUNA_END = 5'd12;
    localparam logic [UPC_W-1:0] UA_CHECKB   = 5'd13;
    localparam logic [UPC_W-1:0] UA_RUNB_SQ  = 5'd14;
    localparam logic [UPC_W-1:0] UA_RUNB     = 5'd15;
    localparam logic [UPC_W-1:0] UA_RUNB_END = 5'd16;

    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_JUMP,
        SEQ_EMIT,
        SEQ_STOP
    } seq_t;

    typedef enum logic [2:0] {
        C_TRUE,
        C_AFTER_SKIP,
        C_RUNA_GO,
        C_X_DONE,
        C_CHECKB_SKIP,
        C_RUNB_GO,
        C_Y_DONE
    } cond_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DELTA,
        OP_ACC_LOAD,
        OP_ACC_ADD,
        OP_HW2_LOAD,
        OP_REACH_LOAD,
        OP_PEND_CUR,
        OP_AFTER,
        OP_RUNA_STEP,
        OP_RUNA_END,
        OP_CHECKB,
        OP_RUNB_STEP,
        OP_RUNB_END
    } op_t;

    typedef enum logic [1:0] {
        WH_ALWAYS,
        WH_TRUE,
        WH_FALSE
    } when_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_DXDX,
        MS_DYDY,
        MS_HWHW,
        MS_EDHW,
        MS_ERR
    } mul_sel_t;

    typedef struct packed {
        seq_t             seq;
        cond_t            cond;
        op_t              op;
        when_t            op_when;
        mul_sel_t         mul;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic tick;
    } start_t;

    typedef struct packed {
        logic idle;
        logic pend_valid;
        logic done;
        logic line_done;
    } seq_stat_t;

    // The control store. Field order: sequencing, condition, operation,
    // operation enable, multiplier source, jump or resume address.
    function automatic uword_t tlr_ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            UA_LD_DELTA: w = '{SEQ_NEXT, C_TRUE, OP_DELTA, WH_ALWAYS, MS_NONE, UA_IDLE};
            UA_LD_SQX:   w = '{SEQ_NEXT, C_TRUE, OP_NONE, WH_ALWAYS, MS_DXDX, UA_IDLE};
            UA_LD_SQY:   w = '{SEQ_NEXT, C_TRUE, OP_ACC_LOAD, WH_ALWAYS, MS_DYDY, UA_IDLE};
            UA_LD_SUM:   w = '{SEQ_NEXT, C_TRUE, OP_ACC_ADD, WH_ALWAYS, MS_HWHW, UA_IDLE};
            UA_LD_HW2:   w = '{SEQ_NEXT, C_TRUE, OP_HW2_LOAD, WH_ALWAYS, MS_NONE, UA_IDLE};
            UA_LD_SCALE: w = '{SEQ_NEXT, C_TRUE, OP_NONE, WH_ALWAYS, MS_EDHW, UA_IDLE};
            UA_LD_LIMIT: w = '{SEQ_NEXT, C_TRUE, OP_REACH_LOAD, WH_ALWAYS, MS_NONE, UA_IDLE};
            UA_TOP:      w = '{SEQ_EMIT, C_TRUE, OP_PEND_CUR, WH_ALWAYS, MS_NONE, UA_AFTER};
            UA_AFTER:    w = '{SEQ_JUMP, C_AFTER_SKIP, OP_AFTER, WH_ALWAYS, MS_NONE, UA_CHECKB};
            UA_RUNA_SQ:  w = '{SEQ_NEXT, C_TRUE, OP_NONE, WH_ALWAYS, MS_ERR, UA_IDLE};
            UA_RUNA:     w = '{SEQ_EMIT, C_RUNA_GO, OP_RUNA_STEP, WH_TRUE, MS_NONE, UA_RUNA_SQ};
            UA_RUNA_END: w = '{SEQ_STOP, C_X_DONE, OP_RUNA_END, WH_FALSE, MS_NONE, UA_CHECKB};
            UA_CHECKB:   w = '{SEQ_JUMP, C_CHECKB_SKIP, OP_CHECKB, WH_FALSE, MS_NONE, UA_TOP};
            UA_RUNB_SQ:  w = '{SEQ_NEXT, C_TRUE, OP_NONE, WH_ALWAYS, MS_ERR, UA_IDLE};
            UA_RUNB:     w = '{SEQ_EMIT, C_RUNB_GO, OP_RUNB_STEP, WH_TRUE, MS_NONE, UA_RUNB_SQ};
            UA_RUNB_END: w = '{SEQ_STOP, C_Y_DONE, OP_RUNB_END, WH_FALSE, MS_NONE, UA_TOP};
            default:     w = '{SEQ_GOTO, C_TRUE, OP_NONE, WH_ALWAYS, MS_NONE, UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/thick_line_rasterizer.sv
// Thick line rasterizer, top level: stream ports, width register, result
// buffering. Depends on tlr_pkg, tlr_sequencer, tlr_datapath and the assert header.
//
// Use: write line_width through cfg_wen/cfg_wdata while the block is idle. On
// the input stream, a transaction with tuser = 0 loads a line from the two
// endpoints in tdata and returns nothing; each transaction with tuser = 1 asks
// for the next covered pixel, which leaves on the output stream with tlast set
// on the last pixel of the line. A pixel request with no line running is
// consumed silently. A load runs the whole load program before the next
// transaction is taken. Between accepted pixel requests the block accepts the
// request, runs the microcode walk to the next pixel, one step per cycle
// through the shared multiplier and error datapath, and then moves the result
// into the output register, from which m_axis_tvalid is driven.
// While the receiver stalls, the output register holds its transaction and a
// further finished pixel waits in a holding register; input is refused until
// that holding register is free. Reset empties both registers, drops any
// line in progress and sets line_width to 1.
`include "thick_line_rasterizer_assert.svh"

module thick_line_rasterizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, from bit 0 up: start_x, start_y, end_x, end_y, zero fill
    input  logic [tlr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: mode (0 load line, 1 next pixel)
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, from bit 0 up: pixel_x, pixel_y, zero fill
    output logic [tlr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tlast: line_done
    output logic                              m_axis_tlast,
    input  logic                              cfg_wen,
    input  logic [tlr_pkg::WIDTH_W-1:0]       cfg_wdata
);
    import tlr_pkg::*;

    logic [WIDTH_W-1:0] line_width_reg, line_width_next;
    logic               res_pending_reg, res_pending_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic               res_last_reg, res_last_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic               out_last_reg, out_last_next;

    logic               in_acc, tick_acc, move_out;
    start_t             start;
    seq_stat_t          stat;
    uword_t             uw;
    logic               cond;
    logic [COORD_W-1:0] pend_x, pend_y;

    // Input is taken only with the sequencer at rest and the holding register free.
    assign s_axis_tready = stat.idle && !res_pending_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign start.load    = in_acc && (s_axis_tuser == MODE_LOAD);
    assign start.tick    = in_acc && (s_axis_tuser == MODE_TICK);
    assign tick_acc      = start.tick && stat.pend_valid;

    tlr_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cond  (cond),
        .uw    (uw),
        .stat  (stat)
    );

    tlr_datapath u_dp (
        .clk        (clk),
        .uw         (uw),
        .load_en    (start.load),
        .start_x    (s_axis_tdata[COORD_W-1:0]),
        .start_y    (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .end_x      (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
        .end_y      (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
        .line_width (line_width_reg),
        .cond       (cond),
        .pend_x     (pend_x),
        .pend_y     (pend_y)
    );

    // The pixel handed out is the look-ahead one held at accept time; the walk
    // that follows only decides whether it was the last.
    assign move_out = res_pending_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        line_width_next  = cfg_wen ? cfg_wdata : line_width_reg;
        res_x_next       = tick_acc ? pend_x : res_x_reg;
        res_y_next       = tick_acc ? pend_y : res_y_reg;
        res_last_next    = stat.done ? stat.line_done : res_last_reg;
        res_pending_next = res_pending_reg;
        out_valid_next   = out_valid_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_last_next    = out_last_reg;

        if (stat.done)
            res_pending_next = 1'b1;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (move_out)
        begin
            out_valid_next   = 1'b1;
            out_x_next       = res_x_reg;
            out_y_next       = res_y_reg;
            out_last_next    = res_last_reg;
            res_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= WIDTH_W'(1);
            res_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_width_reg  <= line_width_next;
            res_pending_reg <= res_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_last_reg <= res_last_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2*COORD_W){1'b0}}, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;

    // A finished walk never finds the holding register still occupied.
    `TLR_ASSERT_IMP(a_done_slot_free, stat.done, !res_pending_reg,
        "pixel walk finished while a result was still held")
    // A pixel request with no line running yields nothing and starts nothing.
    `TLR_ASSERT_NXT(a_idle_tick_silent, start.tick && !stat.pend_valid,
        !res_pending_reg && stat.idle, "pixel request without a line produced activity")
    // The load program runs a fixed number of steps and always ends on a pixel.
    `TLR_ASSERT_IMP(a_load_length, start.load, ##9 (stat.idle && stat.pend_valid),
        "line load did not end with a pending pixel after nine cycles")

endmodule

FILE: rtl/tlr_datapath.sv
// Datapath of the thick line rasterizer: line registers, error terms, the
// shared multiplier and the step conditions. Depends on tlr_pkg.
module tlr_datapath (
    input  logic                        clk,
    input  tlr_pkg::uword_t             uw,
    input  logic                        load_en,
    input  logic [tlr_pkg::COORD_W-1:0] start_x,
    input  logic [tlr_pkg::COORD_W-1:0] start_y,
    input  logic [tlr_pkg::COORD_W-1:0] end_x,
    input  logic [tlr_pkg::COORD_W-1:0] end_y,
    input  logic [tlr_pkg::WIDTH_W-1:0] line_width,
    output logic                        cond,
    output logic [tlr_pkg::COORD_W-1:0] pend_x,
    output logic [tlr_pkg::COORD_W-1:0] pend_y
);
    import tlr_pkg::*;

    logic [COORD_W-1:0]          cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]          target_x_reg, target_x_next, target_y_reg, target_y_next;
    logic [COORD_W-1:0]          dx_reg, dx_next, dy_reg, dy_next;
    logic                        sx_neg_reg, sx_neg_next, sy_neg_reg, sy_neg_next;
    logic signed [RUNERR_W-1:0]  run_err_reg, run_err_next;
    logic signed [SIDEERR_W-1:0] side_err_reg, side_err_next;
    logic signed [SCOORD_W-1:0]  side_coord_reg, side_coord_next;
    logic [ED2_W-1:0]            acc_reg, acc_next;
    logic [HW_W-1:0]             hw_reg, hw_next;
    logic [HW2_W-1:0]            hw2_reg, hw2_next;
    logic [REACH_W-1:0]          reach_reg, reach_next;
    logic [PROD_W-1:0]           prod_reg, prod_next;
    logic [COORD_W-1:0]          pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;

    logic [COORD_W-1:0]          dx_new, dy_new;
    logic signed [RUNERR_W-1:0]  run_err_new;
    logic signed [SIDEERR_W-1:0] run_e, dx_e, dy_e, twice_run;
    logic signed [SIDEERR_W:0]   twice_side, dy_w;
    logic signed [RUNERR_W-1:0]  dx_r, dy_r;
    logic signed [SCOORD_W-1:0]  cur_x_s, cur_y_s, tx_s, ty_s, step_x_s, step_y_s;
    logic signed [SCOORD_W-1:0]  sc_a, sc_b;
    logic [COORD_W-1:0]          cur_step_x, cur_step_y;
    logic [ED2_W-1:0]            acc_sum;
    logic [MUL_A_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]          mul_b;
    logic [PROD_W-1:0]           prod_c;
    logic [HW_W:0]               hw_sum;
    logic                        in_reach, op_en;

    // Sign- and zero-extended views of the stored terms
    assign run_e    = $signed({{(SIDEERR_W-RUNERR_W){run_err_reg[RUNERR_W-1]}}, run_err_reg});
    assign dx_e     = $signed({{(SIDEERR_W-COORD_W){1'b0}}, dx_reg});
    assign dy_e     = $signed({{(SIDEERR_W-COORD_W){1'b0}}, dy_reg});
    assign dx_r     = $signed({{(RUNERR_W-COORD_W){1'b0}}, dx_reg});
    assign dy_r     = $signed({{(RUNERR_W-COORD_W){1'b0}}, dy_reg});
    assign dy_w     = $signed({{(SIDEERR_W+1-COORD_W){1'b0}}, dy_reg});
    assign cur_x_s  = $signed({{(SCOORD_W-COORD_W){1'b0}}, cur_x_reg});
    assign cur_y_s  = $signed({{(SCOORD_W-COORD_W){1'b0}}, cur_y_reg});
    assign tx_s     = $signed({{(SCOORD_W-COORD_W){1'b0}}, target_x_reg});
    assign ty_s     = $signed({{(SCOORD_W-COORD_W){1'b0}}, target_y_reg});
    assign step_x_s = sx_neg_reg ? '1 : SCOORD_W'(1);
    assign step_y_s = sy_neg_reg ? '1 : SCOORD_W'(1);
    assign cur_step_x = sx_neg_reg ? '1 : COORD_W'(1);
    assign cur_step_y = sy_neg_reg ? '1 : COORD_W'(1);
    assign sc_a     = side_coord_reg + step_y_s;
    assign sc_b     = side_coord_reg + step_x_s;
    assign twice_run  = run_e <<< 1;
    assign twice_side = $signed({side_err_reg, 1'b0});
    assign acc_sum  = acc_reg + prod_reg[ED2_W-1:0];
    assign hw_sum   = {1'b0, line_width} + (HW_W+1)'(1);

    assign dx_new = (target_x_reg > cur_x_reg) ? target_x_reg - cur_x_reg
                                               : cur_x_reg - target_x_reg;
    assign dy_new = (target_y_reg > cur_y_reg) ? target_y_reg - cur_y_reg
                                               : cur_y_reg - target_y_reg;
    assign run_err_new = $signed({{(RUNERR_W-COORD_W){1'b0}}, dx_new})
                       - $signed({{(RUNERR_W-COORD_W){1'b0}}, dy_new});

    // The squared side error is registered in prod_reg by the preceding microcode step.
    assign in_reach = side_err_reg[SIDEERR_W-1]
                    || (prod_reg < {{(PROD_W-REACH_W){1'b0}}, reach_reg});

    always_comb
    begin
        unique case (uw.cond)
            C_TRUE:        cond = 1'b1;
            C_AFTER_SKIP:  cond = twice_run < -dx_e;
            C_RUNA_GO:     cond = in_reach && ((side_coord_reg != ty_s) || (dx_reg > dy_reg));
            C_X_DONE:      cond = cur_x_reg == target_x_reg;
            C_CHECKB_SKIP: cond = twice_side > dy_w;
            C_RUNB_GO:     cond = in_reach && ((side_coord_reg != tx_s) || (dx_reg < dy_reg));
            C_Y_DONE:      cond = cur_y_reg == target_y_reg;
            default:       cond = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uw.op_when)
            WH_ALWAYS: op_en = 1'b1;
            WH_TRUE:   op_en = cond;
            WH_FALSE:  op_en = !cond;
            default:   op_en = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uw.mul)
            MS_DXDX:
            begin
                mul_a = {{(MUL_A_W-COORD_W){1'b0}}, dx_reg};
                mul_b = {{(MUL_B_W-COORD_W){1'b0}}, dx_reg};
            end
            MS_DYDY:
            begin
                mul_a = {{(MUL_A_W-COORD_W){1'b0}}, dy_reg};
                mul_b = {{(MUL_B_W-COORD_W){1'b0}}, dy_reg};
            end
            MS_HWHW:
            begin
                mul_a = {{(MUL_A_W-HW_W){1'b0}}, hw_reg};
                mul_b = {{(MUL_B_W-HW_W){1'b0}}, hw_reg};
            end
            MS_EDHW:
            begin
                mul_a = acc_reg;
                mul_b = {{(MUL_B_W-HW2_W){1'b0}}, hw2_reg};
            end
            MS_ERR:
            begin
                mul_a = {{(MUL_A_W-MUL_B_W){1'b0}}, side_err_reg[MUL_B_W-1:0]};
                mul_b = side_err_reg[MUL_B_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};

    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        target_x_next   = target_x_reg;
        target_y_next   = target_y_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sx_neg_next     = sx_neg_reg;
        sy_neg_next     = sy_neg_reg;
        run_err_next    = run_err_reg;
        side_err_next   = side_err_reg;
        side_coord_next = side_coord_reg;
        acc_next        = acc_reg;
        hw_next         = hw_reg;
        hw2_next        = hw2_reg;
        reach_next      = reach_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        prod_next       = (uw.mul == MS_NONE) ? prod_reg : prod_c;

        if (load_en)
        begin
            cur_x_next    = start_x;
            cur_y_next    = start_y;
            target_x_next = end_x;
            target_y_next = end_y;
            hw_next       = hw_sum[HW_W:1];
        end
        else if (op_en)
        begin
            unique case (uw.op)
                OP_NONE:
                begin
                end
                OP_DELTA:
                begin
                    dx_next      = dx_new;
                    dy_next      = dy_new;
                    sx_neg_next  = !(cur_x_reg < target_x_reg);
                    sy_neg_next  = !(cur_y_reg < target_y_reg);
                    run_err_next = run_err_new;
                end
                OP_ACC_LOAD:
                    acc_next = prod_reg[ED2_W-1:0];
                OP_ACC_ADD:
                    // A zero-length line still gets a unit length.
                    acc_next = (acc_sum == '0) ? ED2_W'(1) : acc_sum;
                OP_HW2_LOAD:
                    hw2_next = prod_reg[HW2_W-1:0];
                OP_REACH_LOAD:
                    reach_next = prod_reg[REACH_W-1:0];
                OP_PEND_CUR:
                begin
                    pend_x_next = cur_x_reg;
                    pend_y_next = cur_y_reg;
                end
                OP_AFTER:
                begin
                    if (cond)
                    begin
                        side_err_next   = run_e;
                        side_coord_next = cur_x_s;
                    end
                    else
                    begin
                        side_err_next   = run_e + dy_e;
                        side_coord_next = cur_y_s;
                    end
                end
                OP_RUNA_STEP:
                begin
                    side_coord_next = sc_a;
                    pend_x_next     = cur_x_reg;
                    pend_y_next     = sc_a[COORD_W-1:0];
                    side_err_next   = side_err_reg + dx_e;
                end
                OP_RUNA_END:
                begin
                    side_err_next   = run_e;
                    run_err_next    = run_err_reg - dy_r;
                    side_coord_next = cur_x_s;
                    cur_x_next      = cur_x_reg + cur_step_x;
                end
                OP_CHECKB:
                    side_err_next = dx_e - side_err_reg;
                OP_RUNB_STEP:
                begin
                    side_coord_next = sc_b;
                    pend_x_next     = sc_b[COORD_W-1:0];
                    pend_y_next     = cur_y_reg;
                    side_err_next   = side_err_reg + dy_e;
                end
                OP_RUNB_END:
                begin
                    run_err_next = run_err_reg + dx_r;
                    cur_y_next   = cur_y_reg + cur_step_y;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        target_x_reg   <= target_x_next;
        target_y_reg   <= target_y_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        sx_neg_reg     <= sx_neg_next;
        sy_neg_reg     <= sy_neg_next;
        run_err_reg    <= run_err_next;
        side_err_reg   <= side_err_next;
        side_coord_reg <= side_coord_next;
        acc_reg        <= acc_next;
        hw_reg         <= hw_next;
        hw2_reg        <= hw2_next;
        reach_reg      <= reach_next;
        prod_reg       <= prod_next;
        pend_x_reg     <= pend_x_next;
        pend_y_reg     <= pend_y_next;
    end

    assign pend_x = pend_x_reg;
    assign pend_y = pend_y_reg;

endmodule

FILE: rtl/tlr_sequencer.sv
// Microcode sequencer of the thick line rasterizer: step counter, resume
// address and the look-ahead pixel flag. Depends on tlr_pkg.
module tlr_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  tlr_pkg::start_t    start,
    input  logic               cond,
    output tlr_pkg::uword_t    uw,
    output tlr_pkg::seq_stat_t stat
);
    import tlr_pkg::*;

    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [UPC_W-1:0] resume_reg, resume_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             is_tick_reg, is_tick_next;
    logic             finish, found;
    logic [UPC_W-1:0] upc_inc;

    assign uw      = tlr_ucode(upc_reg);
    assign upc_inc = upc_reg + UPC_W'(1);

    always_comb
    begin
        upc_next        = upc_reg;
        resume_next     = resume_reg;
        pend_valid_next = pend_valid_reg;
        is_tick_next    = is_tick_reg;
        finish          = 1'b0;
        found           = 1'b0;

        if (upc_reg == UA_IDLE)
        begin
            if (start.load)
            begin
                upc_next     = UA_LD_DELTA;
                is_tick_next = 1'b0;
            end
            else if (start.tick && pend_valid_reg)
            begin
                upc_next     = resume_reg;
                is_tick_next = 1'b1;
            end
        end
        else
        begin
            unique case (uw.seq)
                SEQ_NEXT: upc_next = upc_inc;
                SEQ_GOTO: upc_next = uw.target;
                SEQ_JUMP: upc_next = cond ? uw.target : upc_inc;
                SEQ_EMIT:
                begin
                    if (cond)
                    begin
                        finish      = 1'b1;
                        found       = 1'b1;
                        resume_next = uw.target;
                        upc_next    = UA_IDLE;
                    end
                    else
                        upc_next = upc_inc;
                end
                SEQ_STOP:
                begin
                    if (cond)
                    begin
                        finish   = 1'b1;
                        upc_next = UA_IDLE;
                    end
                    else
                        upc_next = uw.target;
                end
                default: upc_next = UA_IDLE;
            endcase
        end

        if (finish)
            pend_valid_next = found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= UA_IDLE;
            resume_reg     <= UA_TOP;
            pend_valid_reg <= 1'b0;
            is_tick_reg    <= 1'b0;
        end
        else
        begin
            upc_reg        <= upc_next;
            resume_reg     <= resume_next;
            pend_valid_reg <= pend_valid_next;
            is_tick_reg    <= is_tick_next;
        end
    end

    assign stat.idle       = upc_reg == UA_IDLE;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.done       = finish && is_tick_reg;
    assign stat.line_done  = !found;

endmodule
